[hdl/dlf_pkg.sv]
// Shared constants for the duplicate line filter.
package dlf_pkg;

    localparam logic [7:0] CARRIAGE_RETURN = 8'd13;

    localparam logic [1:0] VERDICT_NEW  = 2'd0;
    localparam logic [1:0] VERDICT_DUP  = 2'd1;
    localparam logic [1:0] VERDICT_FULL = 2'd2;

endpackage

[hdl/dlf_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
module dlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/dlf_front.sv]
// Front end: cuts the byte stream into pieces and hands finished pieces to the back end.
module dlf_front import dlf_pkg::*; #(
    parameter int ENTRY_BYTES = 80
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [7:0]                     i_char_code,
    input  logic                           i_line_end,
    input  logic                           i_pop,
    output logic                           o_job_valid,
    output logic [$clog2(ENTRY_BYTES)-1:0] o_job_len,
    output logic                           o_pwe,
    output logic [$clog2(ENTRY_BYTES)-1:0] o_pwaddr,
    output logic [7:0]                     o_pwdata
);

    localparam int LW = $clog2(ENTRY_BYTES);
    localparam logic [LW-1:0] PIECE_MAX = LW'(ENTRY_BYTES - 1);

    logic          r_job_valid, n_job_valid;
    logic [LW-1:0] r_job_len, n_job_len;
    logic [LW-1:0] r_plen, n_plen;
    logic [LW-1:0] r_clen, n_clen;
    logic          r_after_cr, n_after_cr;
    logic          accept;
    logic          keep;
    logic [LW-1:0] plen_inc;
    logic [LW-1:0] clen_inc;

    assign accept   = i_start && !r_job_valid;
    assign keep     = !i_line_end && !r_after_cr && (i_char_code != CARRIAGE_RETURN);
    assign plen_inc = r_plen + 1'b1;
    assign clen_inc = keep ? r_clen + 1'b1 : r_clen;

    assign o_pwe    = accept && keep;
    assign o_pwaddr = r_clen;
    assign o_pwdata = i_char_code;

    always_comb begin
        n_job_valid = r_job_valid && !i_pop;
        n_job_len   = r_job_len;
        n_plen      = r_plen;
        n_clen      = r_clen;
        n_after_cr  = r_after_cr;
        if (accept) begin
            if (i_line_end || plen_inc == PIECE_MAX) begin
                // piece closes: hand off and start over
                n_job_valid = 1'b1;
                n_job_len   = i_line_end ? r_clen : clen_inc;
                n_plen      = '0;
                n_clen      = '0;
                n_after_cr  = 1'b0;
            end else begin
                n_plen = plen_inc;
                n_clen = clen_inc;
                if (i_char_code == CARRIAGE_RETURN) begin
                    n_after_cr = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_plen      <= '0;
            r_clen      <= '0;
            r_after_cr  <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            r_plen      <= n_plen;
            r_clen      <= n_clen;
            r_after_cr  <= n_after_cr;
        end
        r_job_len <= n_job_len;
    end

    assign o_job_valid = r_job_valid;
    assign o_job_len   = r_job_len;

endmodule

[hdl/dlf_back.sv]
// Back end: searches the table for a finished piece and stores it when new; an empty piece is stored without a search.
module dlf_back import dlf_pkg::*; #(
    parameter int TABLE_ENTRIES = 512,
    parameter int ENTRY_BYTES   = 80
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    input  logic [$clog2(ENTRY_BYTES)-1:0]   i_job_len,
    output logic                             o_pop,
    output logic [$clog2(ENTRY_BYTES)-1:0]   o_praddr,
    input  logic [7:0]                       i_prdata,
    output logic                             o_valid,
    output logic [1:0]                       o_verdict,
    output logic [8:0]                       o_entry_index,
    output logic [9:0]                       o_entries_used,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] o_count
);

    localparam int LW  = $clog2(ENTRY_BYTES);
    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int SAW = $clog2(TABLE_ENTRIES * ENTRY_BYTES);
    localparam logic [CW-1:0]  FULL_COUNT = CW'(TABLE_ENTRIES);
    localparam logic [SAW-1:0] STRIDE     = SAW'(ENTRY_BYTES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LEN   = 5'b00010,
        S_CMP   = 5'b00100,
        S_COPY  = 5'b01000,
        S_STORE = 5'b10000
    } t_state;

    t_state         r_state, n_state;
    logic [IW-1:0]  r_i, n_i;
    logic [SAW-1:0] r_base, n_base;
    logic [LW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_count, n_count;
    logic [SAW-1:0] r_cbase, n_cbase;
    logic           r_halted, n_halted;
    logic           r_valid, n_valid;
    logic [1:0]     r_verdict, n_verdict;
    logic [8:0]     r_index, n_index;
    logic           emit;

    logic           s_we, l_we;
    logic [7:0]     s_rdata;
    logic [LW-1:0]  l_rdata;
    logic           last_entry;
    logic           last_byte;

    assign last_entry = (CW'(r_i) + 1'b1) == r_count;
    assign last_byte  = (r_j + 1'b1) == i_job_len;

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_base    = r_base;
        n_j       = r_j;
        n_count   = r_count;
        n_cbase   = r_cbase;
        n_halted  = r_halted;
        n_valid   = 1'b0;
        n_verdict = r_verdict;
        n_index   = r_index;
        emit      = 1'b0;
        s_we      = 1'b0;
        l_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_i    = '0;
                    n_base = '0;
                    n_j    = '0;
                    priority if (r_halted) begin
                        emit      = 1'b1;
                        n_verdict = VERDICT_FULL;
                        n_index   = '0;
                    end else if (i_job_len == '0) begin
                        n_state = S_STORE;
                    end else if (r_count == '0) begin
                        n_state = S_COPY;
                    end else begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN, S_CMP: begin
                if (r_state == S_LEN && l_rdata == i_job_len) begin
                    n_j     = '0;
                    n_state = S_CMP;
                end else if (r_state == S_CMP && s_rdata == i_prdata && last_byte) begin
                    emit      = 1'b1;
                    n_verdict = VERDICT_DUP;
                    n_index   = 9'(r_i);
                end else if (r_state == S_CMP && s_rdata == i_prdata) begin
                    n_j = r_j + 1'b1;
                end else if (last_entry) begin
                    // no match anywhere
                    n_j     = '0;
                    n_state = (r_count == FULL_COUNT) ? S_STORE : S_COPY;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_base  = r_base + STRIDE;
                    n_state = S_LEN;
                end
            end
            S_COPY: begin
                s_we = 1'b1;
                n_j  = r_j + 1'b1;
                if (last_byte) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                emit = 1'b1;
                if (r_count == FULL_COUNT) begin
                    n_halted  = 1'b1;
                    n_verdict = VERDICT_FULL;
                    n_index   = '0;
                end else begin
                    l_we      = 1'b1;
                    n_verdict = VERDICT_NEW;
                    n_index   = 9'(r_count);
                    n_count   = r_count + 1'b1;
                    n_cbase   = r_cbase + STRIDE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (emit) begin
            n_valid = 1'b1;
            n_state = S_IDLE;
        end
    end

    assign o_pop    = emit;
    assign o_praddr = n_j;

    // read addresses follow next-state values so data lines up with the registers
    dlf_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * ENTRY_BYTES)) u_bytes (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_cbase + SAW'(r_j)),
        .i_wdata (i_prdata),
        .i_raddr (n_base + SAW'(n_j)),
        .o_rdata (s_rdata)
    );

    dlf_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_lens (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (i_job_len),
        .i_raddr (n_i),
        .o_rdata (l_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cbase  <= '0;
            r_halted <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cbase  <= n_cbase;
            r_halted <= n_halted;
            r_valid  <= n_valid;
        end
        r_i       <= n_i;
        r_base    <= n_base;
        r_j       <= n_j;
        r_verdict <= n_verdict;
        r_index   <= n_index;
    end

    assign o_valid        = r_valid;
    assign o_verdict      = r_verdict;
    assign o_entry_index  = r_index;
    assign o_entries_used = 10'(r_count);
    assign o_count        = r_count;

endmodule

[hdl/duplicate_line_filter.sv]
// Top level of the duplicate line filter.
// Usage:
//   Input: one byte per transaction on i_char_code, or a line end when
//   i_line_end is high. A transaction is taken at a clock edge with start
//   high and busy low.
//   Output: when a piece closes (line end, or 79 raw bytes), one result is
//   shown for a single cycle with o_valid high: o_verdict (new, duplicate,
//   full), o_entry_index and o_entries_used. The receiver cannot stall.
// Busy:
//   An ordinary byte does not raise busy. A closing transaction raises busy
//   until its result is issued: dispatch, then per stored entry checked a
//   length compare and, when the lengths agree, a byte compare up to the
//   first mismatch, then a byte-by-byte copy when the piece is new, then a
//   commit. The single read port of the entry byte memory sets this pace.
//   Busy drops in the cycle o_valid rises.
// Reset:
//   Synchronous, active low; empties the table and the current piece and
//   clears the halted flag. Table memories are not cleared; entries at or above
//   the fill count are never read.
module duplicate_line_filter import dlf_pkg::*; #(
    parameter int TABLE_ENTRIES = 512,
    parameter int ENTRY_BYTES   = 80
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_char_code,
    input  logic       i_line_end,
    output logic       o_valid,
    output logic [1:0] o_verdict,
    output logic [8:0] o_entry_index,
    output logic [9:0] o_entries_used
);

    localparam int LW = $clog2(ENTRY_BYTES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic          job_valid;
    logic [LW-1:0] job_len;
    logic          pop;
    logic          pwe;
    logic [LW-1:0] pwaddr;
    logic [7:0]    pwdata;
    logic [LW-1:0] praddr;
    logic [7:0]    prdata;
    logic [CW-1:0] count;

    dlf_front #(.ENTRY_BYTES(ENTRY_BYTES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .i_pop       (pop),
        .o_job_valid (job_valid),
        .o_job_len   (job_len),
        .o_pwe       (pwe),
        .o_pwaddr    (pwaddr),
        .o_pwdata    (pwdata)
    );

    dlf_ram #(.WIDTH(8), .DEPTH(ENTRY_BYTES)) u_piece (
        .i_clk   (i_clk),
        .i_we    (pwe),
        .i_waddr (pwaddr),
        .i_wdata (pwdata),
        .i_raddr (praddr),
        .o_rdata (prdata)
    );

    dlf_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .ENTRY_BYTES(ENTRY_BYTES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job_len      (job_len),
        .o_pop          (pop),
        .o_praddr       (praddr),
        .i_prdata       (prdata),
        .o_valid        (o_valid),
        .o_verdict      (o_verdict),
        .o_entry_index  (o_entry_index),
        .o_entries_used (o_entries_used),
        .o_count        (count)
    );

    assign busy = job_valid;

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict == VERDICT_NEW || o_verdict == VERDICT_DUP
                     || o_verdict == VERDICT_FULL))
        else $error("bad verdict code");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_busy_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_dup_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict == VERDICT_DUP) |-> (CW'(o_entry_index) < count))
        else $error("duplicate points past the table fill");

endmodule

[verif/tb_duplicate_line_filter.sv]
// Self-checking testbench for the duplicate line filter: directed and random text streams against a predictor.
module tb_duplicate_line_filter;
    import dlf_pkg::*;

    localparam int SLOTS = 512;
    localparam int SLOT_BYTES = 80;
    localparam int SPLIT_AT = SLOT_BYTES - 1;

    typedef struct {
        logic [7:0] ch;
        logic       le;
        bit         hold;
    } text_item_t;

    typedef struct {
        logic [1:0] verdict;
        logic [8:0] index;
        logic [9:0] used;
    } verdict_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_char_code;
    logic       i_line_end;
    logic       o_valid;
    logic [1:0] o_verdict;
    logic [8:0] o_entry_index;
    logic [9:0] o_entries_used;

    duplicate_line_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_char_code(i_char_code), .i_line_end(i_line_end), .o_valid(o_valid),
        .o_verdict(o_verdict), .o_entry_index(o_entry_index),
        .o_entries_used(o_entries_used)
    );

    text_item_t text_q[$];
    verdict_t   verdict_q[$];
    int         errors = 0;
    int         pushed = 0;
    int         results_seen = 0;
    int         dups_seen = 0;
    int         fulls_seen = 0;
    bit         took = 1'b0;

    // predictor state
    logic [7:0] cur_bytes[SLOT_BYTES];
    int         cur_raw = 0;
    int         cur_len = 0;
    bit         cur_after_cr = 1'b0;
    logic [7:0] tbl_bytes[SLOTS][SLOT_BYTES];
    int         tbl_len[SLOTS];
    int         fill = 0;
    bit         stopped = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic close_piece();
        verdict_t v;
        bit hit;
        bit same;
        v.index = '0;
        hit = 1'b0;
        if (stopped) begin
            v.verdict = VERDICT_FULL;
        end else begin
            for (int e = 0; e < fill && !hit; e++) begin
                if (tbl_len[e] == cur_len) begin
                    same = 1'b1;
                    for (int b = 0; b < cur_len; b++)
                        if (tbl_bytes[e][b] !== cur_bytes[b]) same = 1'b0;
                    if (same) begin
                        hit = 1'b1;
                        v.index = e[8:0];
                    end
                end
            end
            if (cur_len == 0 || !hit) begin
                if (fill >= SLOTS) begin
                    stopped = 1'b1;
                    v.verdict = VERDICT_FULL;
                    v.index = '0;
                end else begin
                    for (int b = 0; b < cur_len; b++) tbl_bytes[fill][b] = cur_bytes[b];
                    tbl_len[fill] = cur_len;
                    v.index = fill[8:0];
                    fill++;
                    v.verdict = VERDICT_NEW;
                end
            end else begin
                v.verdict = VERDICT_DUP;
            end
        end
        v.used = fill[9:0];
        cur_raw = 0;
        cur_len = 0;
        cur_after_cr = 1'b0;
        verdict_q.push_back(v);
    endtask

    task automatic filter_take(logic [7:0] ch, logic le);
        if (le) begin
            close_piece();
        end else begin
            cur_raw++;
            if (!cur_after_cr) begin
                if (ch == CARRIAGE_RETURN) cur_after_cr = 1'b1;
                else if (cur_len < SLOT_BYTES) begin
                    cur_bytes[cur_len] = ch;
                    cur_len++;
                end
            end
            if (cur_raw >= SPLIT_AT) close_piece();
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // monitor: results first, then the transaction taken on this edge
    always @(posedge i_clk) begin
        verdict_t w;
        if (i_rst_n) begin
            if (o_valid) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    report("unexpected result", o_verdict, -1);
                end else begin
                    w = verdict_q.pop_front();
                    if (o_verdict !== w.verdict) report("verdict", o_verdict, w.verdict);
                    if (o_entry_index !== w.index) report("entry_index", o_entry_index, w.index);
                    if (o_entries_used !== w.used) report("entries_used", o_entries_used, w.used);
                    if (w.verdict == VERDICT_DUP) dups_seen++;
                    if (w.verdict == VERDICT_FULL) fulls_seen++;
                end
            end
            if (start && !busy) filter_take(i_char_code, i_line_end);
            took <= start && !busy;
        end
    end

    // driver: bursts with random gaps, changes on the falling edge
    int burst_left = 4;
    int gap_left = 0;
    always @(negedge i_clk) begin
        text_item_t t;
        logic nxt;
        nxt = 1'b0;
        if (!i_rst_n) begin
            nxt = 1'b0;
        end else if (start && !took) begin
            nxt = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
        end else if (text_q.size() > 0) begin
            if (text_q[0].hold) begin
                if (verdict_q.size() == 0 && !busy) void'(text_q.pop_front());
            end else begin
                t = text_q.pop_front();
                i_char_code <= t.ch;
                i_line_end <= t.le;
                nxt = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        start <= nxt;
    end

    task automatic put(logic [7:0] ch, logic le);
        text_item_t t;
        t.ch = ch;
        t.le = le;
        t.hold = 1'b0;
        text_q.push_back(t);
        pushed++;
    endtask

    task automatic put_text(string s);
        for (int k = 0; k < s.len(); k++) put(s[k], 1'b0);
        put(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic put_hold();
        text_item_t t;
        t.ch = '0;
        t.le = 1'b0;
        t.hold = 1'b1;
        text_q.push_back(t);
    endtask

    task automatic drain();
        while (text_q.size() > 0 || verdict_q.size() > 0 || start || busy)
            @(posedge i_clk);
    endtask

    initial begin
        string pool[8];
        int n;
        int pick;
        start = 1'b0;
        i_char_code = '0;
        i_line_end = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty, repeats, CR cut, zero and all-ones bytes
        put(8'hFF, 1'b1);
        put_text("AB");
        put_text("AB");
        put_text("A");
        put("A", 1'b0); put("B", 1'b0); put(CARRIAGE_RETURN, 1'b0); put("x", 1'b0);
        put(8'hFF, 1'b1);
        put(8'h00, 1'b0); put(8'h00, 1'b1);
        put(8'hFF, 1'b0); put(8'h00, 1'b1);
        put(CARRIAGE_RETURN, 1'b0); put(8'h00, 1'b1);
        put(8'h00, 1'b1);
        put(8'h00, 1'b0); put(8'h00, 1'b1);
        put_hold();

        for (int p = 0; p < 8; p++) begin
            pool[p] = "";
            n = $urandom_range(0, 6);
            for (int k = 0; k < n; k++) pool[p] = {pool[p], string'(8'($urandom_range(1, 255)))};
        end

        while (pushed < 550) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                put_text(pool[$urandom_range(0, 7)]);
            end else if (pick < 14) begin
                n = $urandom_range(0, 10);
                for (int k = 0; k < n; k++) put(8'($urandom_range(0, 255)), 1'b0);
                put(8'($urandom_range(0, 255)), 1'b1);
            end else if (pick < 15) begin
                // long line, split at the limit, sometimes exactly at it
                n = ($urandom_range(0, 1) == 0) ? SPLIT_AT : $urandom_range(60, 110);
                for (int k = 0; k < n; k++)
                    put((k == 30) ? CARRIAGE_RETURN : 8'($urandom), 1'b0);
                put(8'($urandom_range(0, 255)), 1'b1);
            end else if (pick < 17) begin
                for (int k = 0; k < 3; k++)
                    put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (pick < 19) begin
                pick = $urandom_range(0, 7);
                for (int k = 0; k < pool[pick].len(); k++) put(pool[pick][k], 1'b0);
                put(CARRIAGE_RETURN, 1'b0);
                put(8'($urandom_range(0, 255)), 1'b0);
                put(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                put_hold();
            end
        end
        drain();

        // fill the table with empty pieces, then full-but-running, then halted
        n = SLOTS - fill;
        for (int k = 0; k < n; k++) put(8'($urandom_range(0, 255)), 1'b1);
        put_text("AB");
        put_text("QZ!");
        put_text("AB");
        put(8'h00, 1'b1);
        for (int k = 0; k < SPLIT_AT + 3; k++) put(8'($urandom_range(0, 255)), 1'b0);
        put(8'h00, 1'b1);
        drain();
        repeat (50) @(posedge i_clk);

        $display("covered %0d transactions, %0d results (%0d duplicates, %0d full)",
                 pushed, results_seen, dups_seen, fulls_seen);
        $display("table filled to %0d entries, halted=%0d", fill, stopped);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[duplicate_line_filter.f]
hdl/dlf_pkg.sv
hdl/dlf_ram.sv
hdl/dlf_front.sv
hdl/dlf_back.sv
hdl/duplicate_line_filter.sv
verif/tb_duplicate_line_filter.sv
